// ----- design/ccx_pkg.sv -----
// Shared types and constants for the caption user-data extractor.
package ccx_pkg;

  // Start code and header signature bytes
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] BYTE_START    = 8'h01;
  localparam logic [7:0] BYTE_MPEG2_ID = 8'hB2;
  localparam logic [7:0] BYTE_H264_ID  = 8'h06;
  localparam logic [7:0] BYTE_H265_ID  = 8'h4E;
  localparam logic [7:0] BYTE_SEI_CC   = 8'h04;
  localparam logic [7:0] BYTE_CC_TAG   = 8'h03;

  // Flags byte and triplet first byte fields
  localparam int PROC_BIT  = 6;
  localparam int VALID_BIT = 2;

  // Stream format codes
  localparam logic [1:0] FMT_MPEG2 = 2'd0;
  localparam logic [1:0] FMT_H264  = 2'd1;
  localparam logic [1:0] FMT_H265  = 2'd2;
  localparam logic [1:0] FMT_RAW   = 2'd3;

  // Result kind codes
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_TRIPLET = 1'b1;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic       result_kind;
    logic [1:0] stream_format;
    logic       process_flag;
    logic [4:0] cc_count;
    logic       cc_valid;
    logic [1:0] cc_type;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       last_of_run;
  } ccx_result_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic empty;
    logic full;
  } ccx_qstat_t;

endpackage

// ----- design/ccx_front.sv -----
// Front end: byte parser that finds the start code, classifies the header and builds results.
module ccx_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_raw,
  input  logic                acc,
  input  logic [7:0]          data_byte,
  input  logic                end_of_buffer,
  output logic                push_o,
  output ccx_pkg::ccx_result_t res_o
);
  import ccx_pkg::*;

  localparam logic [2:0] PH_SEEK  = 3'd0;
  localparam logic [2:0] PH_HEAD  = 3'd1;
  localparam logic [2:0] PH_FLAGS = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_TRIP  = 3'd4;
  localparam logic [2:0] PH_IDLE  = 3'd5;

  localparam logic [3:0] HPOS_ID       = 4'd1;
  localparam logic [3:0] HPOS_SUBID    = 4'd2;
  localparam logic [3:0] HPOS_MPEG_TAG = 4'd6;
  localparam logic [3:0] HPOS_SEI_TAG  = 4'd11;

  localparam logic [1:0] TPOS_FIRST  = 2'd0;
  localparam logic [1:0] TPOS_SECOND = 2'd1;
  localparam logic [1:0] TPOS_THIRD  = 2'd2;

  logic       mode_r, mode_nxt;
  logic [1:0] zrun_r, zrun_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [3:0] hpos_r, hpos_nxt;
  logic [1:0] fmt_r, fmt_nxt;
  logic [4:0] left_r, left_nxt;
  logic [1:0] tpos_r, tpos_nxt;
  logic [7:0] hdr_r, hdr_nxt;
  logic [7:0] dat_r, dat_nxt;
  logic       proc_r, proc_nxt;

  logic        has_res;
  ccx_result_t res;
  logic [4:0]  left_dec;
  logic [4:0]  flag_cnt;

  assign left_dec = left_r - 5'd1;
  assign flag_cnt = data_byte[4:0];

  always_comb begin
    mode_nxt  = mode_r;
    zrun_nxt  = zrun_r;
    phase_nxt = phase_r;
    hpos_nxt  = hpos_r;
    fmt_nxt   = fmt_r;
    left_nxt  = left_r;
    tpos_nxt  = tpos_r;
    hdr_nxt   = hdr_r;
    dat_nxt   = dat_r;
    proc_nxt  = proc_r;
    has_res   = 1'b0;
    res       = '0;

    if (acc) begin
      if (mode_r) begin
        if (tpos_r == TPOS_FIRST) begin
          hdr_nxt  = data_byte;
          tpos_nxt = TPOS_SECOND;
        end else if (tpos_r == TPOS_SECOND) begin
          dat_nxt  = data_byte;
          tpos_nxt = TPOS_THIRD;
        end else begin
          has_res           = 1'b1;
          res.result_kind   = KIND_TRIPLET;
          res.stream_format = FMT_RAW;
          res.process_flag  = 1'b1;
          res.cc_valid      = 1'b1;
          res.cc_type       = hdr_r[1:0];
          res.first_byte    = dat_r;
          res.second_byte   = data_byte;
          res.last_of_run   = end_of_buffer;
          tpos_nxt          = TPOS_FIRST;
        end
      end else begin
        case (phase_r)
          PH_SEEK: begin
            if (data_byte == BYTE_ZERO) begin
              if (zrun_r < 2'd2) zrun_nxt = zrun_r + 2'd1;
            end else if (data_byte == BYTE_START && zrun_r >= 2'd2) begin
              phase_nxt = PH_HEAD;
              hpos_nxt  = '0;
            end else begin
              zrun_nxt = '0;
            end
          end
          PH_HEAD: begin
            hpos_nxt = hpos_r + 4'd1;
            if (hpos_nxt == HPOS_ID) begin
              hdr_nxt = data_byte;
              if (data_byte == BYTE_MPEG2_ID)      fmt_nxt = FMT_MPEG2;
              else if (data_byte == BYTE_H264_ID)  fmt_nxt = FMT_H264;
              else if (data_byte == BYTE_H265_ID)  fmt_nxt = FMT_H265;
              else                                 phase_nxt = PH_IDLE;
            end else if (hpos_nxt == HPOS_SUBID) begin
              if (fmt_r != FMT_MPEG2 && data_byte != BYTE_SEI_CC) phase_nxt = PH_IDLE;
            end else if (hpos_nxt == HPOS_MPEG_TAG && fmt_r == FMT_MPEG2) begin
              phase_nxt = (data_byte == BYTE_CC_TAG) ? PH_FLAGS : PH_IDLE;
            end else if (hpos_nxt >= HPOS_SEI_TAG) begin
              phase_nxt = (data_byte == BYTE_CC_TAG) ? PH_FLAGS : PH_IDLE;
            end
          end
          PH_FLAGS: begin
            proc_nxt          = data_byte[PROC_BIT];
            left_nxt          = flag_cnt;
            has_res           = 1'b1;
            res.result_kind   = KIND_HEADER;
            res.stream_format = fmt_r;
            res.process_flag  = data_byte[PROC_BIT];
            res.cc_count      = flag_cnt;
            res.last_of_run   = (flag_cnt == '0) ? 1'b1 : end_of_buffer;
            phase_nxt         = (flag_cnt == '0) ? PH_IDLE : PH_SKIP;
          end
          PH_SKIP: begin
            phase_nxt = PH_TRIP;
            tpos_nxt  = TPOS_FIRST;
          end
          PH_TRIP: begin
            if (tpos_r == TPOS_FIRST) begin
              hdr_nxt  = data_byte;
              tpos_nxt = TPOS_SECOND;
            end else if (tpos_r == TPOS_SECOND) begin
              dat_nxt  = data_byte;
              tpos_nxt = TPOS_THIRD;
            end else begin
              left_nxt          = left_dec;
              has_res           = 1'b1;
              res.result_kind   = KIND_TRIPLET;
              res.stream_format = fmt_r;
              res.process_flag  = proc_r;
              res.cc_valid      = hdr_r[VALID_BIT];
              res.cc_type       = hdr_r[1:0];
              res.first_byte    = dat_r;
              res.second_byte   = data_byte;
              res.last_of_run   = (left_dec == '0) ? 1'b1 : end_of_buffer;
              tpos_nxt          = TPOS_FIRST;
              if (left_dec == '0) phase_nxt = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
    end

    // end of buffer or a register write starts a new buffer
    if ((acc && end_of_buffer) || cfg_we) begin
      zrun_nxt  = '0;
      phase_nxt = PH_SEEK;
      hpos_nxt  = '0;
      fmt_nxt   = '0;
      left_nxt  = '0;
      tpos_nxt  = '0;
      hdr_nxt   = '0;
      dat_nxt   = '0;
      proc_nxt  = 1'b0;
    end
    if (cfg_we) mode_nxt = cfg_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      zrun_r  <= '0;
      phase_r <= PH_SEEK;
      hpos_r  <= '0;
      fmt_r   <= '0;
      left_r  <= '0;
      tpos_r  <= '0;
      hdr_r   <= '0;
      dat_r   <= '0;
      proc_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      zrun_r  <= zrun_nxt;
      phase_r <= phase_nxt;
      hpos_r  <= hpos_nxt;
      fmt_r   <= fmt_nxt;
      left_r  <= left_nxt;
      tpos_r  <= tpos_nxt;
      hdr_r   <= hdr_nxt;
      dat_r   <= dat_nxt;
      proc_r  <= proc_nxt;
    end
  end

  assign push_o = has_res;
  assign res_o  = res;

  a_raw_only_triplets: assert property (@(posedge clk) disable iff (!rst_n)
    (push_o && mode_r) |-> (res_o.result_kind == KIND_TRIPLET &&
                            res_o.stream_format == FMT_RAW))
    else $error("header summary produced in raw mode");

  a_zero_count_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push_o && res_o.result_kind == KIND_HEADER && res_o.cc_count == '0)
      |-> res_o.last_of_run)
    else $error("empty header summary without last_of_run");

endmodule

// ----- design/ccx_queue.sv -----
// Short result queue between the parser and the output stage.
module ccx_queue #(
  parameter int DEPTH = ccx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ccx_pkg::ccx_result_t wdata,
  input  logic                 pop,
  output ccx_pkg::ccx_result_t rdata,
  output ccx_pkg::ccx_qstat_t  stat
);
  import ccx_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  ccx_result_t     mem_r [DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + PW'(1);
    if (pop)  rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + PW'(1);
    if (push && !pop)      cnt_nxt = cnt_r + CW'(1);
    else if (!push && pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

  assign rdata      = mem_r[rptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_FULL);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> !pop)
    else $error("pop from empty queue");

endmodule

// ----- design/ccx_back.sv -----
// Back end: output register that drains the result queue onto the out channel.
module ccx_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ccx_pkg::ccx_qstat_t  qstat,
  input  ccx_pkg::ccx_result_t qdata,
  output logic                 pop_o,
  input  logic                 out_stall,
  output logic                 out_valid,
  output ccx_pkg::ccx_result_t out_res
);
  import ccx_pkg::*;

  logic        valid_r, valid_nxt;
  ccx_result_t res_r;

  assign pop_o = !qstat.empty && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (pop_o)           valid_nxt = 1'b1;
    else if (!out_stall) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop_o) res_r <= qdata;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!valid_r && !qstat.empty) |=> valid_r)
    else $error("queued result not moved to output");

endmodule

// ----- design/cc_user_data_extractor.sv -----
// Top level of the caption user-data extractor.
// Throughput: one byte per cycle; in_stall rises only when the result queue is full.
// A result is written into the queue by the parser, then moved into the output register
// and presented on out_*; out_stall or a busy output register can hold it in the queue.
// Reset (rst_n low, synchronous): parse mode, seeking a start code, queue empty, no output.
// A configuration write is accepted in the cycle it is offered and restarts buffer parsing.
module cc_user_data_extractor #(
  parameter int QUEUE_DEPTH = ccx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_raw_triplet_mode,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_buffer,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_result_kind,
  output logic [1:0] out_stream_format,
  output logic       out_process_flag,
  output logic [4:0] out_cc_count,
  output logic       out_cc_valid,
  output logic [1:0] out_cc_type,
  output logic [7:0] out_first_byte,
  output logic [7:0] out_second_byte,
  output logic       out_last_of_run
);
  import ccx_pkg::*;

  logic        acc;
  logic        push;
  logic        pop;
  ccx_result_t fres;
  ccx_result_t qres;
  ccx_result_t ores;
  ccx_qstat_t  qstat;

  assign cfg_ready = 1'b1;
  assign in_stall  = qstat.full;
  assign acc       = in_valid && !in_stall;

  ccx_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_raw       (cfg_raw_triplet_mode),
    .acc           (acc),
    .data_byte     (in_data_byte),
    .end_of_buffer (in_end_of_buffer),
    .push_o        (push),
    .res_o         (fres)
  );

  ccx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (fres),
    .pop   (pop),
    .rdata (qres),
    .stat  (qstat)
  );

  ccx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .qdata     (qres),
    .pop_o     (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (ores)
  );

  assign out_result_kind   = ores.result_kind;
  assign out_stream_format = ores.stream_format;
  assign out_process_flag  = ores.process_flag;
  assign out_cc_count      = ores.cc_count;
  assign out_cc_valid      = ores.cc_valid;
  assign out_cc_type       = ores.cc_type;
  assign out_first_byte    = ores.first_byte;
  assign out_second_byte   = ores.second_byte;
  assign out_last_of_run   = ores.last_of_run;

endmodule

// ----- bench/cc_result_checker.sv -----
// Checker for the caption extractor: predicts results per byte and compares them.
module cc_result_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_raw_triplet_mode,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_buffer,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_result_kind,
  input  logic [1:0] out_stream_format,
  input  logic       out_process_flag,
  input  logic [4:0] out_cc_count,
  input  logic       out_cc_valid,
  input  logic [1:0] out_cc_type,
  input  logic [7:0] out_first_byte,
  input  logic [7:0] out_second_byte,
  input  logic       out_last_of_run,
  output int         fail_count,
  output int         pending_count
);
  import ccx_pkg::*;

  typedef enum logic [2:0] {
    ST_HUNT, ST_HEADER, ST_FLAGS, ST_SKIP, ST_TRIPLET, ST_IGNORE
  } parse_state_t;

  ccx_result_t  caption_results_q[$];
  int           mismatch_count = 0;

  logic         raw_mode;
  parse_state_t state;
  logic [1:0]   zero_cnt;
  logic [3:0]   hdr_idx;
  logic [1:0]   fmt;
  logic [4:0]   triplets_left;
  logic [1:0]   trip_idx;
  logic [7:0]   lead_byte;
  logic [7:0]   mid_byte;
  logic         proc;

  task automatic clear_buffer();
    state         = ST_HUNT;
    zero_cnt      = 2'd0;
    hdr_idx       = 4'd0;
    fmt           = FMT_MPEG2;
    triplets_left = 5'd0;
    trip_idx      = 2'd0;
    lead_byte     = 8'h00;
    mid_byte      = 8'h00;
    proc          = 1'b0;
  endtask

  // Header checks: an MPEG-2 header ends at offset 6, SEI headers at offset 11
  task automatic parse_header_byte(input logic [7:0] b);
    hdr_idx = hdr_idx + 4'd1;
    if (hdr_idx == 4'd1) begin
      case (b)
        BYTE_MPEG2_ID: fmt = FMT_MPEG2;
        BYTE_H264_ID:  fmt = FMT_H264;
        BYTE_H265_ID:  fmt = FMT_H265;
        default:       state = ST_IGNORE;
      endcase
    end else if (hdr_idx == 4'd2) begin
      if (fmt != FMT_MPEG2 && b != BYTE_SEI_CC) state = ST_IGNORE;
    end else if ((hdr_idx == 4'd6 && fmt == FMT_MPEG2) || hdr_idx >= 4'd11) begin
      state = (b == BYTE_CC_TAG) ? ST_FLAGS : ST_IGNORE;
    end
  endtask

  task automatic parse_user_byte(input logic [7:0] b, input logic eob);
    ccx_result_t r;
    r = '0;
    if (raw_mode) begin
      if (trip_idx == 2'd0) begin
        lead_byte = b;
        trip_idx  = 2'd1;
      end else if (trip_idx == 2'd1) begin
        mid_byte = b;
        trip_idx = 2'd2;
      end else begin
        r.result_kind   = KIND_TRIPLET;
        r.stream_format = FMT_RAW;
        r.process_flag  = 1'b1;
        r.cc_valid      = 1'b1;
        r.cc_type       = lead_byte[1:0];
        r.first_byte    = mid_byte;
        r.second_byte   = b;
        r.last_of_run   = eob;
        caption_results_q.push_back(r);
        trip_idx = 2'd0;
      end
    end else begin
      case (state)
        ST_HUNT: begin
          if (b == BYTE_ZERO) begin
            if (zero_cnt < 2'd2) zero_cnt = zero_cnt + 2'd1;
          end else if (b == BYTE_START && zero_cnt >= 2'd2) begin
            state   = ST_HEADER;
            hdr_idx = 4'd0;
          end else begin
            zero_cnt = 2'd0;
          end
        end
        ST_HEADER: parse_header_byte(b);
        ST_FLAGS: begin
          proc            = b[PROC_BIT];
          triplets_left   = b[4:0];
          r.result_kind   = KIND_HEADER;
          r.stream_format = fmt;
          r.process_flag  = proc;
          r.cc_count      = triplets_left;
          r.last_of_run   = (triplets_left == 5'd0) ? 1'b1 : eob;
          caption_results_q.push_back(r);
          state = (triplets_left == 5'd0) ? ST_IGNORE : ST_SKIP;
        end
        ST_SKIP: begin
          state    = ST_TRIPLET;
          trip_idx = 2'd0;
        end
        ST_TRIPLET: begin
          if (trip_idx == 2'd0) begin
            lead_byte = b;
            trip_idx  = 2'd1;
          end else if (trip_idx == 2'd1) begin
            mid_byte = b;
            trip_idx = 2'd2;
          end else begin
            triplets_left   = triplets_left - 5'd1;
            r.result_kind   = KIND_TRIPLET;
            r.stream_format = fmt;
            r.process_flag  = proc;
            r.cc_valid      = lead_byte[VALID_BIT];
            r.cc_type       = lead_byte[1:0];
            r.first_byte    = mid_byte;
            r.second_byte   = b;
            r.last_of_run   = (triplets_left == 5'd0) ? 1'b1 : eob;
            caption_results_q.push_back(r);
            trip_idx = 2'd0;
            if (triplets_left == 5'd0) state = ST_IGNORE;
          end
        end
        default: ;
      endcase
    end
    if (eob) clear_buffer();
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result(input ccx_result_t want, input ccx_result_t got);
    check_field("result_kind", 8'(want.result_kind), 8'(got.result_kind));
    check_field("stream_format", 8'(want.stream_format), 8'(got.stream_format));
    check_field("process_flag", 8'(want.process_flag), 8'(got.process_flag));
    check_field("cc_count", 8'(want.cc_count), 8'(got.cc_count));
    check_field("cc_valid", 8'(want.cc_valid), 8'(got.cc_valid));
    check_field("cc_type", 8'(want.cc_type), 8'(got.cc_type));
    check_field("first_byte", want.first_byte, got.first_byte);
    check_field("second_byte", want.second_byte, got.second_byte);
    check_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
  endtask

  always @(posedge clk) begin
    ccx_result_t seen;
    if (!rst_n) begin
      raw_mode = 1'b0;
      clear_buffer();
      caption_results_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = {out_result_kind, out_stream_format, out_process_flag, out_cc_count,
                out_cc_valid, out_cc_type, out_first_byte, out_second_byte,
                out_last_of_run};
        if (caption_results_q.size() == 0) begin
          $error("result transaction with nothing expected");
          mismatch_count++;
        end else begin
          check_result(caption_results_q.pop_front(), seen);
        end
      end
      // a mode write also restarts the buffer
      if (cfg_valid && cfg_ready) begin
        raw_mode = cfg_raw_triplet_mode;
        clear_buffer();
      end
      if (in_valid && !in_stall) parse_user_byte(in_data_byte, in_end_of_buffer);
    end
    fail_count    <= mismatch_count;
    pending_count <= caption_results_q.size();
  end

endmodule

// ----- bench/tb_cc_user_data_extractor.sv -----
// Testbench top for the caption extractor: stimulus, flow control and verdict.
module tb_cc_user_data_extractor;
  import ccx_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 8;

  logic       clk                  = 1'b0;
  logic       rst_n                = 1'b0;
  logic       cfg_valid            = 1'b0;
  logic       cfg_raw_triplet_mode = 1'b0;
  logic       in_valid             = 1'b0;
  logic [7:0] in_data_byte         = 8'h00;
  logic       in_end_of_buffer     = 1'b0;
  logic       out_stall            = 1'b0;

  logic       cfg_ready;
  logic       in_stall;
  logic       out_valid;
  logic       out_result_kind;
  logic [1:0] out_stream_format;
  logic       out_process_flag;
  logic [4:0] out_cc_count;
  logic       out_cc_valid;
  logic [1:0] out_cc_type;
  logic [7:0] out_first_byte;
  logic [7:0] out_second_byte;
  logic       out_last_of_run;

  int         fail_count;
  int         pending_count;
  int         tx_idle_pct   = 0;
  int         rx_idle_pct   = 0;
  int         cycle_count   = 0;
  int         phase_items   = 0;
  int         hold_left     = 0;
  logic       hold_request  = 1'b0;
  logic       hold_done     = 1'b0;
  logic [7:0] frame_bytes[$];

  cc_user_data_extractor i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_raw_triplet_mode (cfg_raw_triplet_mode),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_end_of_buffer     (in_end_of_buffer),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_result_kind      (out_result_kind),
    .out_stream_format    (out_stream_format),
    .out_process_flag     (out_process_flag),
    .out_cc_count         (out_cc_count),
    .out_cc_valid         (out_cc_valid),
    .out_cc_type          (out_cc_type),
    .out_first_byte       (out_first_byte),
    .out_second_byte      (out_second_byte),
    .out_last_of_run      (out_last_of_run)
  );

  cc_result_checker i_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_raw_triplet_mode (cfg_raw_triplet_mode),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_end_of_buffer     (in_end_of_buffer),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_result_kind      (out_result_kind),
    .out_stream_format    (out_stream_format),
    .out_process_flag     (out_process_flag),
    .out_cc_count         (out_cc_count),
    .out_cc_valid         (out_cc_valid),
    .out_cc_type          (out_cc_type),
    .out_first_byte       (out_first_byte),
    .out_second_byte      (out_second_byte),
    .out_last_of_run      (out_last_of_run),
    .fail_count           (fail_count),
    .pending_count        (pending_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom();
    return r[7:0];
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_buffer <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      phase_items++;
    end
  endtask

  // Stop offering and wait until every expected result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic raw);
    cfg_valid            <= 1'b1;
    cfg_raw_triplet_mode <= raw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_start_code(input int zeros);
    repeat (zeros) frame_bytes.push_back(BYTE_ZERO);
    frame_bytes.push_back(BYTE_START);
  endtask

  task automatic add_header(input logic [1:0] fmt);
    if (fmt == FMT_MPEG2) begin
      frame_bytes.push_back(BYTE_MPEG2_ID);
      repeat (4) frame_bytes.push_back(rand_byte());
    end else begin
      frame_bytes.push_back((fmt == FMT_H264) ? BYTE_H264_ID : BYTE_H265_ID);
      frame_bytes.push_back(BYTE_SEI_CC);
      repeat (8) frame_bytes.push_back(rand_byte());
    end
    frame_bytes.push_back(BYTE_CC_TAG);
  endtask

  // Mostly well-formed buffers with random content; some noise, broken
  // start codes, corrupted headers and early ends
  task automatic build_parse_frame();
    int         roll;
    int         hdr_start;
    int         count;
    int         cut;
    logic [7:0] flags;
    frame_bytes.delete();
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      repeat ($urandom_range(1, 12)) frame_bytes.push_back(rand_byte());
    end else begin
      repeat ($urandom_range(0, 3)) frame_bytes.push_back(rand_byte());
      add_start_code((roll < 14) ? 1 : $urandom_range(2, 4));
      hdr_start = frame_bytes.size();
      case ($urandom_range(0, 2))
        0:       add_header(FMT_MPEG2);
        1:       add_header(FMT_H264);
        default: add_header(FMT_H265);
      endcase
      if (roll >= 14 && roll < 20)
        frame_bytes[$urandom_range(hdr_start, frame_bytes.size() - 1)] = rand_byte();
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 31) : $urandom_range(0, 4);
      flags      = rand_byte();
      flags[4:0] = count[4:0];
      frame_bytes.push_back(flags);
      frame_bytes.push_back(rand_byte());
      repeat (count * 3) frame_bytes.push_back(rand_byte());
      repeat ($urandom_range(0, 3)) frame_bytes.push_back(rand_byte());
    end
    if ($urandom_range(0, 99) < 15) begin
      cut = $urandom_range(1, frame_bytes.size());
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
  endtask

  task automatic build_raw_frame();
    frame_bytes.delete();
    repeat ($urandom_range(1, 20)) frame_bytes.push_back(rand_byte());
  endtask

  task automatic run_phase(input logic raw, input int tx_pct, input int rx_pct,
                           input int n_items, input bit do_hold, input bit do_pause);
    bit paused;
    paused = 1'b0;
    settle();
    write_mode(raw);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    phase_items = 0;
    while (phase_items < n_items) begin
      if (raw) build_raw_frame();
      else build_parse_frame();
      send_frame();
      if (do_hold && phase_items > 40) hold_request <= 1'b1;
      if (do_pause && !paused && phase_items > n_items / 2) begin
        settle();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(1'b0);
    tx_idle_pct = 20;
    rx_idle_pct = 67;

    // H.265 with full count and proc set, buffer ends right on the first triplet
    frame_bytes.delete();
    add_start_code(2);
    add_header(FMT_H265);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    send_frame();
    // MPEG-2 with zero count, proc clear
    frame_bytes.delete();
    add_start_code(2);
    add_header(FMT_MPEG2);
    frame_bytes.push_back(8'h20);
    send_frame();

    run_phase(1'b0, 20, 67, 450, 1'b0, 1'b1);
    run_phase(1'b1, 20, 67, 150, 1'b0, 1'b0);
    run_phase(1'b0, 67, 20, 450, 1'b0, 1'b0);
    run_phase(1'b1, 67, 20, 150, 1'b0, 1'b0);
    run_phase(1'b0, 0, 0, 450, 1'b1, 1'b0);
    run_phase(1'b1, 0, 0, 150, 1'b0, 1'b0);
    settle();

    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- cc_user_data_extractor.f -----
design/ccx_pkg.sv
design/ccx_front.sv
design/ccx_queue.sv
design/ccx_back.sv
design/cc_user_data_extractor.sv
bench/cc_result_checker.sv
bench/tb_cc_user_data_extractor.sv
